// ===== src/hcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcd_pkg: shared definitions of the chunked body decoder
// Types, character codes, result kinds and the size line parsing function
// that the decoder core uses.
// ----------------------------------------------------------------------------
package hcd_pkg;

  // Sizing of the byte counters and of the size line.
  localparam int COUNT_BITS    = 20;
  localparam int SIZE_LINE_MAX = 16;
  localparam int LEN_W         = $clog2(SIZE_LINE_MAX + 1);
  localparam int VAL_W         = COUNT_BITS + 1;
  localparam int CAP_W         = 21;
  localparam int OUT_LEN_W     = 20;
  localparam int CMP_W         = ((VAL_W > CAP_W) ? VAL_W : CAP_W) + 1;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_CAPACITY = '0;
  localparam logic [CAP_W-1:0]     CAP_RESET        = CAP_W'(4096);

  // Saturation point of the decoded size.
  localparam logic [VAL_W-1:0] COUNT_LIMIT = {1'b1, {COUNT_BITS{1'b0}}};

  // Result kinds.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LFH   = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Message phase.
  typedef enum logic [4:0] {
    PH_LINE  = 5'b00001,
    PH_DATA  = 5'b00010,
    PH_TCR   = 5'b00100,
    PH_TLF   = 5'b01000,
    PH_DRAIN = 5'b10000
  } phase_t;

  // Stage of the number scan on the size line.
  typedef enum logic [4:0] {
    NS_WS     = 5'b00001,
    NS_SIGN   = 5'b00010,
    NS_ZERO   = 5'b00100,
    NS_DIGITS = 5'b01000,
    NS_STOP   = 5'b10000
  } nstage_t;

  // Size line scan state.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    nstage_t          stage;
    logic             neg;
    logic [VAL_W-1:0] value;
  } line_st_t;

  localparam line_st_t LINE_IDLE = '{len: '0, stage: NS_WS, neg: 1'b0, value: '0};

  typedef struct packed {
    line_st_t st;
    logic     bad;
  } commit_t;

  // Input item held in the input register.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_stage_t;

  // Whitespace as the C library sees it: space, HT, LF, VT, FF, CR.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
  endfunction

  // Hex digit decode: valid flag in the top bit, value below.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if ((c >= CH_0) && (c <= CH_9)) begin
      d = c - CH_0;
      return {1'b1, d[3:0]};
    end else if ((c >= CH_LA) && (c <= CH_LFH)) begin
      d = c - CH_LA + 8'd10;
      return {1'b1, d[3:0]};
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      d = c - CH_UA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // Shift one digit into the size, saturating at the count limit.
  function automatic logic [VAL_W-1:0] add_digit(input logic [VAL_W-1:0] v,
                                                 input logic [3:0] d);
    logic [VAL_W+3:0] t;
    t = {v, d};
    if (t > (VAL_W + 4)'(COUNT_LIMIT)) begin
      return COUNT_LIMIT;
    end
    return t[VAL_W-1:0];
  endfunction

  // Take one character of the size line into the scan state.
  function automatic commit_t commit_char(input line_st_t st, input logic [7:0] c);
    commit_t    r;
    logic [4:0] h;
    r     = '{st: st, bad: 1'b0};
    h     = hex_digit(c);
    r.st.len = st.len + LEN_W'(1);
    if (r.st.len >= LEN_W'(SIZE_LINE_MAX)) begin
      r.bad = 1'b1;
    end else begin
      case (st.stage)
        NS_WS, NS_SIGN: begin
          if ((st.stage == NS_WS) && is_space(c)) begin
            r.bad = 1'b0;
          end else if ((st.stage == NS_WS) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
            r.st.neg   = (c == CH_MINUS);
            r.st.stage = NS_SIGN;
          end else if (!h[4]) begin
            r.bad = 1'b1;
          end else if (h[3:0] == 4'd0) begin
            r.st.stage = NS_ZERO;
          end else begin
            r.st.stage = NS_DIGITS;
            r.st.value = add_digit(st.value, h[3:0]);
          end
        end
        NS_ZERO: begin
          if ((c == CH_LX) || (c == CH_UX)) begin
            r.st.stage = NS_DIGITS;
          end else if (h[4]) begin
            r.st.stage = NS_DIGITS;
            r.st.value = add_digit(st.value, h[3:0]);
          end else begin
            r.st.stage = NS_STOP;
          end
        end
        NS_DIGITS: begin
          if (h[4]) begin
            r.st.value = add_digit(st.value, h[3:0]);
          end else begin
            r.st.stage = NS_STOP;
          end
        end
        default: begin
          r.bad = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== src/hcd_in_if.sv =====
// ----------------------------------------------------------------------------
// hcd_in_if: raw body byte channel
// Carries one body byte and its final-byte flag per transfer.
// ----------------------------------------------------------------------------
interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ===== src/hcd_out_if.sv =====
// ----------------------------------------------------------------------------
// hcd_out_if: decoder result channel
// Carries one payload byte or a final status per transfer.
// ----------------------------------------------------------------------------
interface hcd_out_if;
  import hcd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           result_kind;
  logic [7:0]           data_byte;
  logic [OUT_LEN_W-1:0] decoded_length;

  modport source (output valid, output result_kind, output data_byte,
                  output decoded_length, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input decoded_length, output ready);
endinterface

// ===== src/http_chunked_body_decoder_top.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top: HTTP chunked body decoder
// Takes a chunked body one byte per transfer, passes the payload bytes
// through and reports success with the decoded length, or an error.
// ----------------------------------------------------------------------------
//   Channel   Direction  Payload                                   Handshake
//   in_ch     in         in_byte[7:0], last_byte                   valid/ready
//   out_ch    out        result_kind[1:0], data_byte[7:0],         valid/ready
//                        decoded_length[19:0]
//   APB       in/out     paddr[2:0], pwdata/prdata[31:0]           psel/penable
//
// One byte per cycle is sustained while the result channel does not stall; a
// byte passes from its input transfer through the input register and then the
// result register. The state update between them sets the rate.
// Reset (rst_n low, synchronous) empties both registers and starts a new
// message; the capacity register returns to 4096.
// A stalled result channel holds the result register and then the input.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  hcd_in_if.sink                         in_ch,
  hcd_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hcd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hcd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import hcd_pkg::*;

  logic             advance;
  in_stage_t        stage;
  logic [CAP_W-1:0] capacity;

  // Configuration registers.
  hcd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // Input register.
  hcd_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  // Decoder state and result register.
  hcd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .advance  (advance),
    .capacity (capacity),
    .out_ch   (out_ch)
  );

endmodule

// ===== src/hcd_cfg.sv =====
// ----------------------------------------------------------------------------
// hcd_cfg: configuration register block
// APB-style slave that holds the output capacity register.
// ----------------------------------------------------------------------------
module hcd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hcd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hcd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [hcd_pkg::CAP_W-1:0]      capacity
);
  import hcd_pkg::*;

  logic [CAP_W-1:0]     cap_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_OUT_CAPACITY);
  assign pready  = 1'b1;

  // Capacity register, written in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (wr_en) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_OUT_CAPACITY) begin
      prdata = APB_DATA_W'(cap_r);
    end
  end

  assign capacity = cap_r;

endmodule

// ===== src/hcd_in_reg.sv =====
// ----------------------------------------------------------------------------
// hcd_in_reg: input register
// Captures each body byte transfer and holds it for the decoder core.
// ----------------------------------------------------------------------------
module hcd_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  hcd_in_if.sink             in_ch,
  input  logic               advance,
  output hcd_pkg::in_stage_t stage
);
  import hcd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     in_fire;

  // The register is free when empty or when its item moves on this cycle.
  assign in_ch.ready = !valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= '{in_byte: in_ch.in_byte, last_byte: in_ch.last_byte};
    end
  end

  assign stage = '{valid: valid_r, item: item_r};

endmodule

// ===== src/hcd_core.sv =====
// ----------------------------------------------------------------------------
// hcd_core: chunked body decoder core
// Tracks the message phase and size line scan, decides the result of each
// byte and holds it in the result register.
// ----------------------------------------------------------------------------
module hcd_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hcd_pkg::in_stage_t        stage,
  output logic                      advance,
  input  logic [hcd_pkg::CAP_W-1:0] capacity,
  hcd_out_if.source                 out_ch
);
  import hcd_pkg::*;

  // Decoder state.
  phase_t                phase_r, phase_nxt;
  line_st_t              line_r, line_nxt;
  logic                  cr_pending_r, cr_pending_nxt;
  logic [COUNT_BITS-1:0] chunk_r, chunk_nxt;
  logic [COUNT_BITS-1:0] written_r, written_nxt;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_kind_r;
  logic [7:0]           out_data_r;
  logic [OUT_LEN_W-1:0] out_len_r;

  // Per-byte decisions.
  logic                 fire;
  logic [7:0]           b;
  logic                 last;
  logic                 has_res;
  logic [1:0]           res_kind;
  logic [7:0]           res_data;
  logic [OUT_LEN_W-1:0] res_len;
  logic                 msg_start;
  logic [VAL_W-1:0]     cap_c;
  logic [CMP_W-1:0]     span_end;
  commit_t              c_cr;
  commit_t              c_b;
  line_st_t             st_a;
  logic                 bad_a;

  assign advance = !out_valid_r || out_ch.ready;
  assign fire    = stage.valid && advance;
  assign b       = stage.item.in_byte;
  assign last    = stage.item.last_byte;

  // Capacity clamped to the count limit, and the end of the chunk just read.
  assign cap_c = (CMP_W'(capacity) >= CMP_W'(COUNT_LIMIT)) ?
                 COUNT_LIMIT : VAL_W'(capacity);
  assign span_end = CMP_W'(written_r) + CMP_W'(line_r.value);

  // Size line characters: a held CR first, then the new byte.
  assign c_cr  = commit_char(line_r, CH_CR);
  assign st_a  = cr_pending_r ? c_cr.st : line_r;
  assign bad_a = cr_pending_r && c_cr.bad;
  assign c_b   = commit_char(st_a, b);

  // Next state and result of the byte in the input register.
  always_comb begin
    phase_nxt      = phase_r;
    line_nxt       = line_r;
    cr_pending_nxt = cr_pending_r;
    chunk_nxt      = chunk_r;
    written_nxt    = written_r;
    has_res        = 1'b0;
    res_kind       = KIND_ERR;
    res_data       = 8'h00;
    res_len        = OUT_LEN_W'(written_r);
    msg_start      = 1'b0;

    if (phase_r == PH_DRAIN) begin
      msg_start = last;
    end else begin
      if (capacity == '0) begin
        has_res = 1'b1;
      end else begin
        case (phase_r)
          PH_LINE: begin
            if (cr_pending_r && (b == CH_LF)) begin
              // End of the size line.
              cr_pending_nxt = 1'b0;
              if ((line_r.len == '0) || (line_r.stage == NS_WS) ||
                  (line_r.stage == NS_SIGN) ||
                  (line_r.neg && (line_r.value != '0))) begin
                has_res = 1'b1;
              end else if (line_r.value == '0) begin
                has_res  = 1'b1;
                res_kind = KIND_OK;
              end else if (span_end >= CMP_W'(cap_c)) begin
                has_res = 1'b1;
              end else if (last) begin
                has_res = 1'b1;
              end else begin
                chunk_nxt = COUNT_BITS'(line_r.value);
                phase_nxt = PH_DATA;
              end
            end else if (bad_a) begin
              has_res = 1'b1;
            end else if (b == CH_CR) begin
              line_nxt       = st_a;
              cr_pending_nxt = 1'b1;
            end else if (c_b.bad) begin
              has_res = 1'b1;
            end else begin
              line_nxt       = c_b.st;
              cr_pending_nxt = 1'b0;
            end
          end
          PH_DATA: begin
            if (last) begin
              has_res = 1'b1;
            end else begin
              // Payload byte passes through.
              has_res     = 1'b1;
              res_kind    = KIND_DATA;
              res_data    = b;
              written_nxt = written_r + COUNT_BITS'(1);
              res_len     = OUT_LEN_W'(written_nxt);
              chunk_nxt   = chunk_r - COUNT_BITS'(1);
              if (chunk_r == COUNT_BITS'(1)) begin
                phase_nxt = PH_TCR;
              end
            end
          end
          PH_TCR: begin
            if (b == CH_CR) begin
              phase_nxt = PH_TLF;
            end else begin
              has_res = 1'b1;
            end
          end
          PH_TLF: begin
            if (b == CH_LF) begin
              phase_nxt      = PH_LINE;
              line_nxt       = LINE_IDLE;
              cr_pending_nxt = 1'b0;
            end else begin
              has_res = 1'b1;
            end
          end
          default: begin
            has_res = 1'b1;
          end
        endcase
      end

      // The final byte always closes the message.
      if (!has_res && last) begin
        has_res  = 1'b1;
        res_kind = KIND_ERR;
      end

      if (has_res && (res_kind != KIND_DATA)) begin
        if (last) begin
          msg_start = 1'b1;
        end else begin
          phase_nxt = PH_DRAIN;
        end
      end
    end

    if (msg_start) begin
      phase_nxt      = PH_LINE;
      line_nxt       = LINE_IDLE;
      cr_pending_nxt = 1'b0;
      chunk_nxt      = '0;
      written_nxt    = '0;
    end
  end

  // State update on each byte that leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LINE;
      line_r       <= LINE_IDLE;
      cr_pending_r <= 1'b0;
      chunk_r      <= '0;
      written_r    <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      line_r       <= line_nxt;
      cr_pending_r <= cr_pending_nxt;
      chunk_r      <= chunk_nxt;
      written_r    <= written_nxt;
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = fire && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire && has_res) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_len_r  <= res_len;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_kind_r;
  assign out_ch.data_byte      = out_data_r;
  assign out_ch.decoded_length = out_len_r;

`ifndef SYNTHESIS
  // A chunk in progress always has bytes left.
  a_chunk_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (chunk_r != '0))
    else $error("payload phase with no bytes left in the chunk");

  // The size line never holds more characters than allowed.
  a_line_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LINE) |-> (line_r.len < LEN_W'(SIZE_LINE_MAX)))
    else $error("size line length out of range");

  // The decoded size saturates at the count limit.
  a_size_sat: assert property (@(posedge clk) disable iff (!rst_n)
    line_r.value <= COUNT_LIMIT)
    else $error("size value above saturation point");

  // A status result before the final byte leads into the drain phase.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && has_res && (res_kind != KIND_DATA) && !last) |=> (phase_r == PH_DRAIN))
    else $error("status result did not start draining");

  // Every result decided is held in the result register.
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && has_res) |=> out_valid_r)
    else $error("result lost");
`endif

endmodule

// ===== test/http_chunked_body_decoder_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top_tb: self-checking bench of the chunked decoder
// Drives chunked bodies into the decoder, starting with a few hand-made ones
// and then random messages that are mostly well formed. Some messages carry
// one flaw each. A scoreboard predicts every payload byte and final status
// and compares them with what the decoder returns. The capacity register is
// reprogrammed between phases, to settings from zero up to the count limit.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top_tb;
  import hcd_pkg::*;

  localparam int               NO_RESULT     = -1;
  localparam int               IDLE_LIMIT    = 4000;
  localparam int               HOLD_CYCLES   = 400;
  localparam int               SETTLE_CYCLES = 8;
  localparam int               PRINT_LIMIT   = 40;
  localparam logic [CAP_W-1:0] CAP_MAX       = CAP_W'(1048576);

  // Ways a random message can be damaged.
  typedef enum int {
    FLAW_BYTE,
    FLAW_CUT,
    FLAW_LONG,
    FLAW_MINUS,
    FLAW_NODIGIT,
    FLAW_EMPTY,
    FLAW_NOISE
  } flaw_t;

  // Stall patterns of the result side.
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_ONE_IN_FOUR,
    RX_MOSTLY
  } rx_mode_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           data;
    logic [OUT_LEN_W-1:0] length;
  } dec_result_t;

  // Scoreboard: tracks the decoder state per body byte and holds the
  // results that are still due.
  class body_decode_scoreboard;
    logic [CAP_W-1:0]      capacity;
    phase_t                msg_phase;
    logic [LEN_W-1:0]      line_chars;
    logic                  cr_held;
    nstage_t               scan;
    logic                  minus;
    logic [VAL_W-1:0]      size_acc;
    logic [COUNT_BITS-1:0] chunk_left;
    logic [COUNT_BITS-1:0] emitted;
    dec_result_t           expected_results[$];
    int                    fail_count;

    function new();
      capacity   = CAP_RESET;
      fail_count = 0;
      restart_message();
    endfunction

    task report(input string msg);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
        $display("MISMATCH @%0t: %s", $time, msg);
      end
    endtask

    function void clear_line();
      line_chars = '0;
      cr_held    = 1'b0;
      scan       = NS_WS;
      minus      = 1'b0;
      size_acc   = '0;
    endfunction

    function void restart_message();
      msg_phase  = PH_LINE;
      clear_line();
      chunk_left = '0;
      emitted    = '0;
    endfunction

    function int nibble(input logic [7:0] c);
      if ((c >= CH_0) && (c <= CH_9)) return int'(c - CH_0);
      if ((c >= CH_LA) && (c <= CH_LFH)) return int'(c - CH_LA) + 10;
      if ((c >= CH_UA) && (c <= CH_UF)) return int'(c - CH_UA) + 10;
      return -1;
    endfunction

    function bit white(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
    endfunction

    // The size saturates just above the largest count.
    function void shift_in(input int d);
      longint v;
      v = longint'(size_acc) * 16 + d;
      size_acc = (v > longint'(COUNT_LIMIT)) ? COUNT_LIMIT : v[VAL_W-1:0];
    endfunction

    // One character of the size line; returns 1 when it is an error.
    function bit take_char(input logic [7:0] c);
      int d;
      d = nibble(c);
      line_chars++;
      if (line_chars >= LEN_W'(SIZE_LINE_MAX)) return 1'b1;
      if ((scan == NS_WS) && white(c)) return 1'b0;
      if ((scan == NS_WS) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
        minus = (c == CH_MINUS);
        scan  = NS_SIGN;
        return 1'b0;
      end
      case (scan)
        NS_WS, NS_SIGN: begin
          if (d < 0) return 1'b1;
          if (d == 0) begin
            scan = NS_ZERO;
          end else begin
            scan = NS_DIGITS;
            shift_in(d);
          end
        end
        NS_ZERO: begin
          if ((c == CH_LX) || (c == CH_UX)) begin
            scan = NS_DIGITS;
          end else if (d >= 0) begin
            scan = NS_DIGITS;
            shift_in(d);
          end else begin
            scan = NS_STOP;
          end
        end
        NS_DIGITS: begin
          if (d >= 0) shift_in(d);
          else scan = NS_STOP;
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    // CR LF closes the size line: decide between a new chunk, the end of
    // the message and an error.
    function int close_line(input logic last);
      logic [CAP_W-1:0] cap;
      cap = (capacity < COUNT_LIMIT) ? capacity : COUNT_LIMIT;
      if (line_chars == '0) return KIND_ERR;
      if ((scan == NS_WS) || (scan == NS_SIGN)) return KIND_ERR;
      if (minus && (size_acc != '0)) return KIND_ERR;
      if (size_acc == '0) return KIND_OK;
      if (longint'(emitted) + longint'(size_acc) >= longint'(cap)) return KIND_ERR;
      if (last) return KIND_ERR;
      chunk_left = size_acc[COUNT_BITS-1:0];
      msg_phase  = PH_DATA;
      return NO_RESULT;
    endfunction

    // Called for every accepted body byte.
    function void take_body_byte(input logic [7:0] b, input logic last);
      int          kind;
      logic [7:0]  data;
      bit          bad;
      dec_result_t r;
      kind = NO_RESULT;
      data = 8'h00;
      if (msg_phase == PH_DRAIN) begin
        if (last) restart_message();
        return;
      end
      if (capacity == '0) begin
        kind = KIND_ERR;
      end else begin
        case (msg_phase)
          PH_LINE: begin
            if (cr_held && (b == CH_LF)) begin
              cr_held = 1'b0;
              kind    = close_line(last);
            end else begin
              bad = 1'b0;
              // A CR without LF behind it is an ordinary line character.
              if (cr_held) begin
                cr_held = 1'b0;
                bad     = take_char(CH_CR);
              end
              if (!bad) begin
                if (b == CH_CR) cr_held = 1'b1;
                else bad = take_char(b);
              end
              if (bad) kind = KIND_ERR;
            end
          end
          PH_DATA: begin
            if (last) begin
              kind = KIND_ERR;
            end else begin
              kind = KIND_DATA;
              data = b;
              emitted++;
              chunk_left--;
              if (chunk_left == '0) msg_phase = PH_TCR;
            end
          end
          PH_TCR: begin
            if (b == CH_CR) msg_phase = PH_TLF;
            else kind = KIND_ERR;
          end
          default: begin
            if (b == CH_LF) begin
              msg_phase = PH_LINE;
              clear_line();
            end else begin
              kind = KIND_ERR;
            end
          end
        endcase
      end
      if ((kind == NO_RESULT) && last) kind = KIND_ERR;
      if (kind == NO_RESULT) return;
      r.kind   = 2'(kind);
      r.data   = data;
      r.length = emitted;
      expected_results.push_back(r);
      if (r.kind != KIND_DATA) begin
        if (last) restart_message();
        else msg_phase = PH_DRAIN;
      end
    endfunction

    // Called for every accepted result transfer.
    task check_result(input logic [1:0] kind, input logic [7:0] data,
                      input logic [OUT_LEN_W-1:0] length);
      dec_result_t e;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d data %02h length %0d",
                         kind, data, length));
        return;
      end
      e = expected_results.pop_front();
      if (kind !== e.kind) begin
        report($sformatf("result_kind %0d, expected %0d", kind, e.kind));
      end
      if (data !== e.data) begin
        report($sformatf("data_byte %02h, expected %02h", data, e.data));
      end
      if (length !== e.length) begin
        report($sformatf("decoded_length %0d, expected %0d", length, e.length));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  hold_req;
  int                    idle_cycles = 0;
  in_item_t              body_q[$];
  body_decode_scoreboard sb;

  hcd_in_if  in_ch ();
  hcd_out_if out_ch ();

  http_chunked_body_decoder_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Every transfer on either channel goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.result_kind, out_ch.data_byte, out_ch.decoded_length);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.take_body_byte(in_ch.in_byte, in_ch.last_byte);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results still due",
               idle_cycles, sb.expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: segments of different stall patterns, and one long
  // hold-off on request so that the decoder backs up into its input.
  initial begin : result_sink
    int       seg_len;
    int       tick;
    rx_mode_t mode;
    bit       held;
    out_ch.ready <= 1'b0;
    tick = 0;
    held = 1'b0;
    forever begin
      seg_len = $urandom_range(8, 80);
      mode    = rx_mode_t'($urandom_range(0, 3));
      repeat (seg_len) begin
        @(posedge clk);
        tick++;
        if (hold_req && !held) begin
          held = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            RX_ALWAYS:      out_ch.ready <= 1'b1;
            RX_COIN:        out_ch.ready <= 1'($urandom_range(0, 1));
            RX_ONE_IN_FOUR: out_ch.ready <= ((tick % 4) == 0);
            default:        out_ch.ready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    body_q.push_back({b, 1'b0});
  endfunction

  function automatic void add_str(input string s);
    foreach (s[i]) add_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  function automatic void end_body();
    body_q[body_q.size()-1].last_byte = 1'b1;
  endfunction

  // A size line in one of the forms strtoul accepts: optional whitespace
  // (now and then with a lone CR), sign, prefix, mixed case digits and an
  // extension after the number.
  function automatic void add_size_line(input logic [31:0] chunk_size);
    string      digits;
    int         n;
    logic [7:0] ch;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: add_byte(CH_SPACE);
        1: add_byte(CH_HT);
        2: add_byte(8'h0B);
        default: add_byte(8'h0C);
      endcase
    end
    if ($urandom_range(0, 19) == 0) begin
      add_byte(CH_CR);
      add_byte(CH_SPACE);
    end
    n = $urandom_range(0, 9);
    if (n == 0) add_byte(CH_PLUS);
    else if ((n == 1) && (chunk_size == 0)) add_byte(CH_MINUS);
    case ($urandom_range(0, 7))
      0: add_str("0x");
      1: add_str("0X");
      2: add_byte(CH_0);
      default: ;
    endcase
    digits = $sformatf("%0h", chunk_size);
    foreach (digits[i]) begin
      ch = digits[i];
      if ((ch >= CH_LA) && ($urandom_range(0, 1) == 1)) ch = ch - 8'h20;
      add_byte(ch);
    end
    if ($urandom_range(0, 7) == 0) add_str(";ext");
    add_crlf();
  endfunction

  // One random message, well formed about two times in three.
  function automatic void gen_message();
    int          first;
    int          n_chunks;
    int          n;
    int          pick;
    logic [31:0] chunk_size;
    first    = body_q.size();
    n_chunks = $urandom_range(0, 3);
    for (int c = 0; c < n_chunks; c++) begin
      n = $urandom_range(0, 15);
      if (n == 0) chunk_size = $urandom();
      else if (n < 3) chunk_size = $urandom_range(25, 200);
      else chunk_size = $urandom_range(1, 24);
      add_size_line(chunk_size);
      // Huge chunks get no payload: the rest of the body runs into them.
      if (chunk_size <= 200) begin
        repeat (chunk_size) add_byte(8'($urandom_range(0, 255)));
        add_crlf();
      end
    end
    add_size_line(0);
    if ($urandom_range(0, 3) == 0) add_crlf();
    pick = $urandom_range(0, 19);
    if (pick <= int'(FLAW_NOISE)) begin
      case (flaw_t'(pick))
        FLAW_BYTE: begin
          n = $urandom_range(first, body_q.size() - 1);
          body_q[n].in_byte = 8'($urandom_range(0, 255));
        end
        FLAW_CUT: begin
          n = $urandom_range(first + 1, body_q.size());
          while (body_q.size() > n) void'(body_q.pop_back());
        end
        FLAW_LONG: begin
          n = $urandom_range(14, 18);
          repeat (n) body_q.insert(first, {CH_SPACE, 1'b0});
        end
        FLAW_MINUS:   body_q.insert(first, {CH_MINUS, 1'b0});
        FLAW_NODIGIT: body_q.insert(first, {8'h7A, 1'b0});
        FLAW_EMPTY: begin
          body_q.insert(first, {CH_LF, 1'b0});
          body_q.insert(first, {CH_CR, 1'b0});
        end
        default: begin
          while (body_q.size() > first) void'(body_q.pop_back());
          n = $urandom_range(1, 8);
          repeat (n) add_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
    end_body();
  endfunction

  // Sends the queued body bytes in bursts with random gaps between them.
  task automatic push_body();
    int burst;
    int gap;
    burst = 0;
    foreach (body_q[i]) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_ch.valid     <= 1'b1;
      in_ch.in_byte   <= body_q[i].in_byte;
      in_ch.last_byte <= body_q[i].last_byte;
      do @(posedge clk); while (!in_ch.ready);
      burst--;
    end
    in_ch.valid <= 1'b0;
    body_q.delete();
  endtask

  task automatic send_messages(input int n_bytes);
    while (body_q.size() < n_bytes) gen_message();
    push_body();
  endtask

  // Waits until all due results are in and the pipeline has emptied.
  task automatic settle();
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_OUT_CAPACITY, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes the capacity, tells the scoreboard and reads the value back.
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    logic [APB_DATA_W-1:0] readback;
    apb_access(1'b1, APB_DATA_W'(value), readback);
    sb.capacity = value;
    apb_access(1'b0, '0, readback);
    if (readback !== APB_DATA_W'(value)) begin
      sb.report($sformatf("out_capacity reads %0d, written %0d", readback, value));
    end
  endtask

  initial begin : stimulus
    sb = new();
    rst_n           <= 1'b0;
    hold_req        <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= 8'h00;
    in_ch.last_byte <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hand-made bodies at the reset capacity.
    // An empty size line.
    add_crlf();
    end_body();
    // Minus zero is a zero size and ends the message with success.
    add_str("-0");
    add_crlf();
    end_body();
    // A negative size.
    add_str("-1");
    add_crlf();
    end_body();
    // No digits: the error comes at once and the final byte is dropped.
    add_str("g0");
    end_body();
    // Both extreme byte values as payload, then a clean end.
    add_str("2");
    add_crlf();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_crlf();
    add_str("0");
    add_crlf();
    end_body();
    // A payload byte where the trailer CR belongs, also the final byte.
    add_str("1");
    add_crlf();
    add_str("AB");
    end_body();
    // The body ends on the size line.
    add_str(" 1");
    end_body();
    push_body();

    // Random bodies; the result side holds off for a long stretch early on.
    settle();
    hold_req <= 1'b1;
    send_messages(200);

    settle();
    set_capacity(CAP_W'(1));
    send_messages(80);

    settle();
    set_capacity(CAP_MAX);
    send_messages(150);

    // Zero capacity turns the first byte of every message into an error.
    settle();
    set_capacity('0);
    send_messages(30);

    // Small capacities that the chunks run into.
    repeat (3) begin
      settle();
      set_capacity(CAP_W'($urandom_range(2, 400)));
      send_messages(75);
    end

    settle();
    set_capacity(CAP_RESET);
    send_messages(160);

    settle();
    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hcd_pkg.sv
src/hcd_in_if.sv
src/hcd_out_if.sv
src/hcd_cfg.sv
src/hcd_in_reg.sv
src/hcd_core.sv
src/http_chunked_body_decoder_top.sv
test/http_chunked_body_decoder_top_tb.sv
